[hw/rtl/cpg_pkg.sv]
// Shared package for the circle point generator.
// Holds field widths, request codes, decision constants and the batch record type.
// Depends on nothing.
package cpg_pkg;

    localparam int COORD_BITS = 10;   // default width of center and radius
    localparam int FIFO_DEPTH = 2;    // batch records held between front and back

    localparam int IN_W = 10;         // center and radius fields
    localparam int PT_W = 12;         // point coordinates, two's complement
    localparam int X_W  = 11;         // x offset, unsigned
    localparam int Y_W  = 12;         // y offset, two's complement
    localparam int D_W  = 16;         // decision variable, two's complement

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [D_W-1:0] D_INIT     = D_W'(3);
    localparam logic [D_W-1:0] D_INC_KEEP = D_W'(6);
    localparam logic [D_W-1:0] D_INC_DEC  = D_W'(10);

    // One batch of eight symmetric points, fully described.
    typedef struct packed {
        logic [IN_W-1:0]       cx;
        logic [IN_W-1:0]       cy;
        logic [X_W-1:0]        x;
        logic signed [Y_W-1:0] y;
        logic                  done;
    } batch_t;

endpackage

[hw/rtl/circle_point_generator.sv]
// Top level of the circle point generator (Bresenham circle rasterizer, eight-way symmetry).
// Connects the front end, the batch queue and the back end.
// Depends on cpg_pkg, cpg_front, cpg_fifo and cpg_back.

// A start item (req_type 0) loads the center and radius and yields the eight symmetric
// points of (0, radius); each step item (req_type 1) runs one midpoint iteration and
// yields the next eight points, and the batch in which x first passes y carries
// circle_done on its eighth point and ends the circle. A step item while no circle is
// in progress is accepted and yields nothing. Points come out in the order
// (cx+x,cy+y), (cx+y,cy+x), (cx+x,cy-y), (cx+y,cy-x), (cx-x,cy-y), (cx-y,cy-x),
// (cx-x,cy+y), (cx-y,cy+x), as 12-bit two's complement values. The front end updates
// the circle state in the cycle an item is accepted and places one batch record into a
// queue of FIFO_DEPTH entries; the back end expands each record into eight points, one
// per cycle while the consumer keeps popping, through an output register. The sustained
// rate of point-producing items is therefore set by the back end's one-point-per-cycle
// output. Items are taken on consecutive cycles until the queue fills (FIFO_DEPTH
// records plus the one being expanded), and when the block is otherwise idle the first
// point of an item passes through the queue, the record register and the output register.
module circle_point_generator #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS,
    parameter int FIFO_DEPTH = cpg_pkg::FIFO_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            req_type,
    input  logic [cpg_pkg::IN_W-1:0]        center_x,
    input  logic [cpg_pkg::IN_W-1:0]        center_y,
    input  logic [cpg_pkg::IN_W-1:0]        radius,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [cpg_pkg::PT_W-1:0] point_x,
    output logic signed [cpg_pkg::PT_W-1:0] point_y,
    output logic                            last_of_batch,
    output logic                            circle_done
);

    // Batch records flow from the front end through the queue to the back end.
    cpg_pkg::batch_t q_wdata;
    cpg_pkg::batch_t q_rdata;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;

    cpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .req_type (req_type),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    cpg_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_rdata),
        .empty (q_empty)
    );

    cpg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .point_x       (point_x),
        .point_y       (point_y),
        .last_of_batch (last_of_batch),
        .circle_done   (circle_done)
    );

`ifndef SYNTHESIS
    // The front end never pushes a record into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("batch record pushed into a full queue");

    // The back end never takes a record from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("batch record popped from an empty queue");

    // The end of a circle is only flagged on the last point of a batch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && circle_done) |-> last_of_batch)
        else $error("circle_done on a point that does not end its batch");

    // A start item is never pushed as the record marked final.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !(q_wdata.done && req_type == cpg_pkg::REQ_START))
        else $error("start item marked as the final batch");
`endif

endmodule

[hw/rtl/cpg_front.sv]
// Front end of the circle point generator: accepts items, loads a circle on a start and runs one iteration per step.
// Holds the circle state and pushes one batch record per item that yields points.
// Depends on cpg_pkg.
module cpg_front #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       req_type,
    input  logic [cpg_pkg::IN_W-1:0]   center_x,
    input  logic [cpg_pkg::IN_W-1:0]   center_y,
    input  logic [cpg_pkg::IN_W-1:0]   radius,
    input  logic                       q_full,
    output logic                       q_push,
    output cpg_pkg::batch_t            q_data
);

    localparam int IW = cpg_pkg::IN_W;
    localparam int XW = cpg_pkg::X_W;
    localparam int YW = cpg_pkg::Y_W;
    localparam int DW = cpg_pkg::D_W;
    localparam logic [IW-1:0] CMASK = IW'((1 << COORD_BITS) - 1);

    logic [IW-1:0] center_col_reg, center_col_next;
    logic [IW-1:0] center_row_reg, center_row_next;
    logic [XW-1:0] x_offset_reg, x_offset_next;
    logic [YW-1:0] y_offset_reg, y_offset_next;
    logic [DW-1:0] decision_reg, decision_next;
    logic          active_reg, active_next;

    logic          accept;
    logic          is_start;
    logic [IW-1:0] cx_in, cy_in, r_in;
    logic [YW-1:0] y_start;
    logic [DW-1:0] d_start;
    logic [DW-1:0] x_wide, y_wide;
    logic [XW-1:0] x_step;
    logic [YW-1:0] y_step;
    logic [DW-1:0] d_step;
    logic          done_step;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign is_start = (req_type == cpg_pkg::REQ_START);

    assign cx_in   = center_x & CMASK;
    assign cy_in   = center_y & CMASK;
    assign r_in    = radius & CMASK;
    assign y_start = {{(YW-IW){1'b0}}, r_in};
    assign d_start = cpg_pkg::D_INIT - {{(DW-IW-1){1'b0}}, r_in, 1'b0};

    assign x_wide = {{(DW-XW){1'b0}}, x_offset_reg};
    assign y_wide = {{(DW-YW){y_offset_reg[YW-1]}}, y_offset_reg};
    assign x_step = x_offset_reg + XW'(1);

    // One midpoint iteration; all arithmetic wraps at the state widths.
    always_comb
    begin
        if (decision_reg[DW-1])
        begin
            d_step = decision_reg + (x_wide << 2) + cpg_pkg::D_INC_KEEP;
            y_step = y_offset_reg;
        end
        else
        begin
            d_step = decision_reg + ((x_wide - y_wide) << 2) + cpg_pkg::D_INC_DEC;
            y_step = y_offset_reg - YW'(1);
        end
    end

    assign done_step = $signed({2'b00, x_step}) > $signed({y_step[YW-1], y_step});

    always_comb
    begin
        center_col_next = center_col_reg;
        center_row_next = center_row_reg;
        x_offset_next   = x_offset_reg;
        y_offset_next   = y_offset_reg;
        decision_next   = decision_reg;
        active_next     = active_reg;
        if (accept && is_start)
        begin
            center_col_next = cx_in;
            center_row_next = cy_in;
            x_offset_next   = '0;
            y_offset_next   = y_start;
            decision_next   = d_start;
            active_next     = 1'b1;
        end
        else if (accept && active_reg)
        begin
            x_offset_next = x_step;
            y_offset_next = y_step;
            decision_next = d_step;
            active_next   = !done_step;
        end
    end

    assign q_push = accept && (is_start || active_reg);

    always_comb
    begin
        if (is_start)
        begin
            q_data.cx   = cx_in;
            q_data.cy   = cy_in;
            q_data.x    = '0;
            q_data.y    = y_start;
            q_data.done = 1'b0;
        end
        else
        begin
            q_data.cx   = center_col_reg;
            q_data.cy   = center_row_reg;
            q_data.x    = x_step;
            q_data.y    = y_step;
            q_data.done = done_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg <= '0;
            center_row_reg <= '0;
            x_offset_reg   <= '0;
            y_offset_reg   <= '0;
            decision_reg   <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            center_col_reg <= center_col_next;
            center_row_reg <= center_row_next;
            x_offset_reg   <= x_offset_next;
            y_offset_reg   <= y_offset_next;
            decision_reg   <= decision_next;
            active_reg     <= active_next;
        end
    end

endmodule

[hw/rtl/cpg_fifo.sv]
// Small queue of batch records between the front and back ends.
// Register array with read and write pointers and an occupancy count.
// Depends on cpg_pkg.
module cpg_fifo #(
    parameter int DEPTH = cpg_pkg::FIFO_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpg_pkg::batch_t din,
    output logic            full,
    input  logic            pop,
    output cpg_pkg::batch_t dout,
    output logic            empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cpg_pkg::batch_t entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/cpg_back.sv]
// Back end of the circle point generator: expands one batch record into eight points.
// One point per cycle while the consumer keeps popping, into an output register that the consumer pops.
// Depends on cpg_pkg.
module cpg_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  cpg_pkg::batch_t               q_data,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [cpg_pkg::PT_W-1:0] point_x,
    output logic signed [cpg_pkg::PT_W-1:0] point_y,
    output logic                          last_of_batch,
    output logic                          circle_done
);

    localparam int PW = cpg_pkg::PT_W;
    localparam int IW = cpg_pkg::IN_W;
    localparam int XW = cpg_pkg::X_W;

    // Octant order within a batch.
    localparam logic [2:0] OCT_XP_YP = 3'd0;
    localparam logic [2:0] OCT_YP_XP = 3'd1;
    localparam logic [2:0] OCT_XP_YN = 3'd2;
    localparam logic [2:0] OCT_YP_XN = 3'd3;
    localparam logic [2:0] OCT_XN_YN = 3'd4;
    localparam logic [2:0] OCT_YN_XN = 3'd5;
    localparam logic [2:0] OCT_XN_YP = 3'd6;
    localparam logic [2:0] OCT_YN_XP = 3'd7;

    cpg_pkg::batch_t desc_reg;
    logic            busy_reg, busy_next;
    logic [2:0]      idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [PW-1:0]   px_reg, py_reg;
    logic            last_reg, done_reg;

    logic            advance;
    logic            at_last;
    logic [PW-1:0]   cx, cy, xo, yo;
    logic [PW-1:0]   px_calc, py_calc;

    assign advance = busy_reg && (!out_valid_reg || pop);
    assign at_last = (idx_reg == OCT_YN_XP);
    assign q_pop   = (!busy_reg || (advance && at_last)) && !q_empty;

    assign cx = {{(PW-IW){1'b0}}, desc_reg.cx};
    assign cy = {{(PW-IW){1'b0}}, desc_reg.cy};
    assign xo = {{(PW-XW){1'b0}}, desc_reg.x};
    assign yo = desc_reg.y;

    always_comb
    begin
        case (idx_reg)
            OCT_XP_YP: begin px_calc = cx + xo; py_calc = cy + yo; end
            OCT_YP_XP: begin px_calc = cx + yo; py_calc = cy + xo; end
            OCT_XP_YN: begin px_calc = cx + xo; py_calc = cy - yo; end
            OCT_YP_XN: begin px_calc = cx + yo; py_calc = cy - xo; end
            OCT_XN_YN: begin px_calc = cx - xo; py_calc = cy - yo; end
            OCT_YN_XN: begin px_calc = cx - yo; py_calc = cy - xo; end
            OCT_XN_YP: begin px_calc = cx - xo; py_calc = cy + yo; end
            OCT_YN_XP: begin px_calc = cx - yo; py_calc = cy + xo; end
            default:   begin px_calc = cx;      py_calc = cy;      end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            idx_next  = OCT_XP_YP;
        end
        else if (advance && at_last)
        begin
            busy_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= OCT_XP_YP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_data;
        end
        if (advance)
        begin
            px_reg   <= px_calc;
            py_reg   <= py_calc;
            last_reg <= at_last;
            done_reg <= at_last && desc_reg.done;
        end
    end

    assign empty         = !out_valid_reg;
    assign point_x       = px_reg;
    assign point_y       = py_reg;
    assign last_of_batch = last_reg;
    assign circle_done   = done_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for circle_point_generator, the Bresenham circle rasterizer.
// It predicts every plotted point from its own copy of the circle state and checks each one.
// Depends on cpg_pkg and the circle_point_generator RTL.
`timescale 1ns / 1ps

module tb_top;

    // Field widths as the block defines them.
    localparam int IN_W = cpg_pkg::IN_W;
    localparam int PT_W = cpg_pkg::PT_W;
    localparam int X_W  = cpg_pkg::X_W;
    localparam int Y_W  = cpg_pkg::Y_W;
    localparam int D_W  = cpg_pkg::D_W;

    // Cycles without any accepted item on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to wait after the last expected point so that stray points would show up.
    localparam int TAIL_CYCLES = 16;

    // One plotted point as the block should present it.
    typedef struct {
        logic signed [PT_W-1:0] px;
        logic signed [PT_W-1:0] py;
        logic                   last;
        logic                   done;
    } point_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic                   req_type;
    logic [IN_W-1:0]        center_x;
    logic [IN_W-1:0]        center_y;
    logic [IN_W-1:0]        radius;
    logic                   empty;
    logic                   pop;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   last_of_batch;
    logic                   circle_done;

    // Circle state as the block should hold it, updated when an item is accepted.
    logic [IN_W-1:0]        circ_cx;
    logic [IN_W-1:0]        circ_cy;
    logic [X_W-1:0]         circ_x;
    logic signed [Y_W-1:0]  circ_y;
    logic signed [D_W-1:0]  circ_d;
    bit                     circ_active;

    // Points that the block owes us, oldest first.
    point_t points_due[$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    bit failed;

    circle_point_generator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .empty        (empty),
        .pop          (pop),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_batch(last_of_batch),
        .circle_done  (circle_done)
    );

    always #5 clk = ~clk;

    // Appends one expected point; coordinates wrap to the 12-bit output width.
    function automatic void add_point(int px, int py, bit last, bit done);
        point_t p;
        p.px   = PT_W'(px);
        p.py   = PT_W'(py);
        p.last = last;
        p.done = done;
        points_due.push_back(p);
    endfunction

    // Queues the eight symmetric points of the current offsets, in the block's order.
    function automatic void queue_batch(bit closing);
        int cx;
        int cy;
        int x;
        int y;
        cx = int'(circ_cx);
        cy = int'(circ_cy);
        x  = int'(circ_x);
        y  = int'(circ_y);
        add_point(cx + x, cy + y, 1'b0, 1'b0);
        add_point(cx + y, cy + x, 1'b0, 1'b0);
        add_point(cx + x, cy - y, 1'b0, 1'b0);
        add_point(cx + y, cy - x, 1'b0, 1'b0);
        add_point(cx - x, cy - y, 1'b0, 1'b0);
        add_point(cx - y, cy - x, 1'b0, 1'b0);
        add_point(cx - x, cy + y, 1'b0, 1'b0);
        add_point(cx - y, cy + x, 1'b1, closing);
    endfunction

    // Applies one accepted item to the circle state and queues the points it yields.
    // A start always yields a batch and is never the last one; a step yields a batch only
    // while a circle is in progress, and the batch in which x passes y ends the circle.
    function automatic void advance_circle(logic kind, logic [IN_W-1:0] cx,
                                           logic [IN_W-1:0] cy, logic [IN_W-1:0] r);
        int xi;
        int yi;
        int di;
        bit closing;
        if (kind == cpg_pkg::REQ_START)
        begin
            circ_cx     = cx;
            circ_cy     = cy;
            circ_x      = '0;
            circ_y      = Y_W'(int'(r));
            circ_d      = D_W'(3 - 2 * int'(r));
            circ_active = 1'b1;
            queue_batch(1'b0);
        end
        else if (circ_active)
        begin
            xi = int'(circ_x);
            yi = int'(circ_y);
            di = int'(circ_d);
            // Midpoint decision: stay on this row while the decision is negative,
            // otherwise move one row inward.
            if (di < 0)
            begin
                di = di + 4 * xi + 6;
            end
            else
            begin
                di = di + 4 * (xi - yi) + 10;
                yi = yi - 1;
            end
            xi = xi + 1;
            circ_x  = X_W'(xi);
            circ_y  = Y_W'(yi);
            circ_d  = D_W'(di);
            closing = int'(circ_x) > int'(circ_y);
            if (closing)
            begin
                circ_active = 1'b0;
            end
            queue_batch(closing);
        end
    endfunction

    // Offers one item, with random idle cycles ahead of it, and waits until it is taken.
    // Inputs change only at rising edges, and full is read as it stood before the edge.
    task automatic send_item(input logic kind, input logic [IN_W-1:0] cx,
                             input logic [IN_W-1:0] cy, input logic [IN_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        req_type <= kind;
        center_x <= cx;
        center_y <= cy;
        radius   <= r;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        advance_circle(kind, cx, cy, r);
    endtask

    // A step carries center and radius fields that the block must ignore.
    task automatic send_step();
        send_item(cpg_pkg::REQ_STEP, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
    endtask

    // Steps with no circle in progress must be accepted and produce nothing.
    task automatic test_steps_without_circle();
        send_item(cpg_pkg::REQ_STEP, '1, '1, '1);
        send_item(cpg_pkg::REQ_STEP, '0, '0, '0);
    endtask

    // A zero radius plots the center eight times, and the next step ends the circle
    // with y at minus one. A further step finds no circle and yields nothing.
    task automatic test_zero_radius();
        send_item(cpg_pkg::REQ_START, '0, '0, '0);
        send_step();
        send_step();
    endtask

    // Largest center and radius, the origin with the largest radius (negative
    // coordinates), and a radius of one in a corner, run to its end.
    task automatic test_extreme_fields();
        send_item(cpg_pkg::REQ_START, '1, '1, '1);
        send_step();
        send_step();
        send_item(cpg_pkg::REQ_START, '0, '0, '1);
        send_step();
        send_step();
        send_item(cpg_pkg::REQ_START, '1, '0, IN_W'(1));
        while (circ_active)
        begin
            send_step();
        end
    endtask

    // A start while a circle is in progress drops the old circle.
    task automatic test_restart_mid_circle();
        send_item(cpg_pkg::REQ_START, IN_W'(512), IN_W'(300), IN_W'(5));
        send_step();
        send_step();
        send_item(cpg_pkg::REQ_START, IN_W'(100), IN_W'(900), IN_W'(2));
        while (circ_active)
        begin
            send_step();
        end
        send_step();
    endtask

    // Mostly complete circles with random centers and radii, small radii for the most
    // part; some circles are cut short by a new start and stray steps fall between
    // circles. Only items that produce points are counted.
    task automatic test_random_circles(input int n_items);
        int produced;
        int roll;
        logic [IN_W-1:0] r;
        produced = 0;
        while (produced < n_items)
        begin
            roll = $urandom_range(99);
            if (circ_active && roll >= 8)
            begin
                send_step();
                produced++;
            end
            else if (!circ_active && roll < 10)
            begin
                send_step();
            end
            else
            begin
                if ($urandom_range(9) == 0)
                begin
                    r = IN_W'($urandom_range(1023));
                end
                else
                begin
                    r = IN_W'($urandom_range(24));
                end
                send_item(cpg_pkg::REQ_START, IN_W'($urandom), IN_W'($urandom), r);
                produced++;
            end
        end
    endtask

    // The receiver drops pop at random in the chosen share of cycles.
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Checks every accepted point against the oldest expected one, and counts cycles
    // in which neither side moves an item. All signals are read as they stood before
    // the edge.
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (pop && !empty)
            begin
                if (points_due.size() == 0)
                begin
                    $error("unexpected point (%0d, %0d)", point_x, point_y);
                    failed = 1'b1;
                end
                else
                begin
                    want = points_due.pop_front();
                    if (point_x !== want.px)
                    begin
                        $error("point_x: expected %0d, got %0d", want.px, point_x);
                        failed = 1'b1;
                    end
                    if (point_y !== want.py)
                    begin
                        $error("point_y: expected %0d, got %0d", want.py, point_y);
                        failed = 1'b1;
                    end
                    if (last_of_batch !== want.last)
                    begin
                        $error("last_of_batch: expected %0b, got %0b", want.last,
                               last_of_batch);
                        failed = 1'b1;
                    end
                    if (circle_done !== want.done)
                    begin
                        $error("circle_done: expected %0b, got %0b", want.done,
                               circle_done);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Ends a hung run.
    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        req_type      = cpg_pkg::REQ_START;
        center_x      = '0;
        center_y      = '0;
        radius        = '0;
        stall_cycles  = 0;
        failed        = 1'b0;
        circ_cx       = '0;
        circ_cy       = '0;
        circ_x        = '0;
        circ_y        = '0;
        circ_d        = '0;
        circ_active   = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 70;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First phase: the sender pauses now and then, the receiver most of the time.
        test_steps_without_circle();
        test_zero_radius();
        test_extreme_fields();
        test_restart_mid_circle();
        test_random_circles(38);

        // Second phase: the sender is the slow side.
        send_idle_pct = 70;
        recv_idle_pct = 27;
        test_random_circles(38);

        // Last phase: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_circles(30);
        push <= 1'b0;

        while (points_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (!failed && points_due.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
